### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam int VALUE_W       = 32;
   localparam int PRIO_W        = 16;
   localparam int CAP_W         = 5;
   localparam int STATUS_W      = 2;
   localparam int COUNT_OUT_W   = 5;
   localparam int DEPTH_DEFAULT = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast from the top level to every cell in the chain.
   typedef struct packed {
      logic                      push_en;
      logic                      pop_en;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  priority_key;
   } ctl_type;

endpackage

`default_nettype wire

### sv/spq_ifs.sv
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface spq_req_if;
   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [spq_pkg::VALUE_W-1:0] item_value;
   logic signed [spq_pkg::PRIO_W-1:0]  item_priority;

   modport source (output valid, opcode, item_value, item_priority, input ready);
   modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [spq_pkg::STATUS_W-1:0]           status;
   logic signed [spq_pkg::VALUE_W-1:0]     popped_value;
   logic                                   is_empty;
   logic                                   is_full;
   logic [spq_pkg::COUNT_OUT_W-1:0]        entry_count;

   modport source (output valid, status, popped_value, is_empty, is_full, entry_count,
                   input ready);
   modport sink   (input valid, status, popped_value, is_empty, is_full, entry_count,
                   output ready);
endinterface

`default_nettype wire

### sv/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell (
   input  wire                                 clock,
   input  wire spq_pkg::ctl_type               ctl,
   input  wire                                 occupied,
   input  wire                                 left_stays,
   input  wire  signed [spq_pkg::VALUE_W-1:0]  left_value,
   input  wire  signed [spq_pkg::PRIO_W-1:0]   left_priority,
   input  wire  signed [spq_pkg::VALUE_W-1:0]  right_value,
   input  wire  signed [spq_pkg::PRIO_W-1:0]   right_priority,
   output logic                                stays,
   output logic signed [spq_pkg::VALUE_W-1:0]  value,
   output logic signed [spq_pkg::PRIO_W-1:0]   priority_key
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic signed [spq_pkg::PRIO_W-1:0]  prio_ff, prio_in;

   // An entry stays put on a push when it is held and its key is not greater than the new key.
   assign stays = occupied && !(prio_ff > ctl.priority_key);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctl.pop_en) begin
         value_in = right_value;
         prio_in  = right_priority;
      end else if (ctl.push_en && !stays) begin
         if (left_stays) begin
            value_in = ctl.value;
            prio_in  = ctl.priority_key;
         end else begin
            value_in = left_value;
            prio_in  = left_priority;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value        = value_ff;
   assign priority_key = prio_ff;

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// Sorted priority queue built as a chain of entry cells with a registered response.
// Latency: the response word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle while responses are taken; every cell updates in parallel.
// The request side stalls only while a response word waits and is not being taken.
// Reset (synchronous, active high) empties the queue, drops any pending response
// and sets the capacity register to 16. Slot contents are not cleared.
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   spq_req_if.sink                          req_chan,
   spq_rsp_if.source                        rsp_chan,
   input  wire                              csr_wr_en,
   input  wire  [spq_pkg::CAP_W-1:0]        csr_wr_data
);

   // The count must hold DEPTH itself; comparisons with the 5-bit capacity use the
   // wider of the two widths.
   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

   logic [spq_pkg::CAP_W-1:0] capacity_ff;
   logic [CW-1:0]             count_ff, count_in;

   logic                                   rsp_valid_ff;
   logic [spq_pkg::STATUS_W-1:0]           rsp_status_ff, rsp_status_in;
   logic signed [spq_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                                   rsp_empty_ff, rsp_empty_in;
   logic                                   rsp_full_ff, rsp_full_in;
   logic [spq_pkg::COUNT_OUT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic             accept;
   logic             queue_full;
   logic             full_after;
   logic             is_pop;
   spq_pkg::ctl_type ctl;

   // Per-cell chain wiring.
   logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic signed [spq_pkg::PRIO_W-1:0]  cell_prio  [DEPTH];
   logic                               cell_stays [DEPTH];

   // The request side is free whenever the response register is empty or is being
   // drained in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_pop         = (req_chan.opcode == spq_pkg::OP_POP);

   // The queue reads as full when the count reaches the capacity, or DEPTH when the
   // capacity register is set above it. A zero capacity therefore always reads full.
   assign queue_full = (WW'(count_ff) >= WW'(capacity_ff)) || (WW'(count_ff) == WW'(DEPTH));
   assign full_after = (WW'(count_in) >= WW'(capacity_ff)) || (WW'(count_in) == WW'(DEPTH));

   always_comb begin
      ctl.push_en      = accept && !is_pop && !queue_full;
      ctl.pop_en       = accept && is_pop && (count_ff != '0);
      ctl.value        = req_chan.item_value;
      ctl.priority_key = req_chan.item_priority;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Response fields for the word accepted in this cycle. The popped value is the
   // front cell, read before the chain shifts left.
   always_comb begin
      rsp_status_in = spq_pkg::ST_DONE;
      rsp_value_in  = '0;
      if (!is_pop && queue_full) begin
         rsp_status_in = spq_pkg::ST_FULL;
      end else if (is_pop && (count_ff == '0)) begin
         rsp_status_in = spq_pkg::ST_EMPTY;
      end else if (is_pop) begin
         rsp_value_in = cell_value[0];
      end
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = full_after;
      rsp_count_in = spq_pkg::COUNT_OUT_W'(WW'(count_in));
   end

   // Each cell decides from its own key and its left neighbor's verdict whether to
   // keep its entry, take the new one, or take the neighbor's. The boundary cells see
   // a permanently staying neighbor on the left and a copy of themselves on the right.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                               left_stays;
      logic signed [spq_pkg::VALUE_W-1:0] left_value;
      logic signed [spq_pkg::PRIO_W-1:0]  left_prio;
      logic signed [spq_pkg::VALUE_W-1:0] right_value;
      logic signed [spq_pkg::PRIO_W-1:0]  right_prio;

      if (i == 0) begin : g_head
         assign left_stays = 1'b1;
         assign left_value = cell_value[i];
         assign left_prio  = cell_prio[i];
      end else begin : g_body
         assign left_stays = cell_stays[i-1];
         assign left_value = cell_value[i-1];
         assign left_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = cell_value[i];
         assign right_prio  = cell_prio[i];
      end else begin : g_mid
         assign right_value = cell_value[i+1];
         assign right_prio  = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock          (clock),
         .ctl            (ctl),
         .occupied       (count_ff > CW'(i)),
         .left_stays     (left_stays),
         .left_value     (left_value),
         .left_priority  (left_prio),
         .right_value    (right_value),
         .right_priority (right_prio),
         .stays          (cell_stays[i]),
         .value          (cell_value[i]),
         .priority_key   (cell_prio[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= spq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.popped_value = rsp_value_ff;
   assign rsp_chan.is_empty     = rsp_empty_ff;
   assign rsp_chan.is_full      = rsp_full_ff;
   assign rsp_chan.entry_count  = rsp_count_ff;

endmodule

`default_nettype wire

### tb/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed table, random phases.
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

   localparam int DEPTH        = spq_pkg::DEPTH_DEFAULT;
   localparam int VALUE_W      = spq_pkg::VALUE_W;
   localparam int PRIO_W       = spq_pkg::PRIO_W;
   localparam int CAP_W        = spq_pkg::CAP_W;
   localparam int COUNT_OUT_W  = spq_pkg::COUNT_OUT_W;
   localparam int N_PHASES     = 8;
   localparam int PHASE_WORDS  = 85;
   localparam int REPORT_LIMIT = 10;

   // One response word as the queue should report it.
   typedef struct {
      spq_pkg::status_type       status;
      logic signed [VALUE_W-1:0] popped;
      logic                      empty;
      logic                      full;
      logic [COUNT_OUT_W-1:0]    count;
   } rsp_word_type;

   // A directed row either sends one request word or rewrites the capacity
   // register (the new capacity then sits in the value column).
   typedef enum logic {
      ROW_WORD,
      ROW_CAP
   } row_kind_type;

   typedef struct {
      row_kind_type              kind;
      spq_pkg::op_type           op;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
      bit                        typed;
      spq_pkg::status_type       st;
      logic signed [VALUE_W-1:0] popped;
      bit                        empty;
      bit                        full;
      logic [COUNT_OUT_W-1:0]    count;
   } dir_row_type;

   localparam int N_ROWS = 29;

   // Rows with typed set carry an expectation that can be read off directly;
   // all other rows are checked against the predictor below. Each row gives the
   // request on its first line and the typed expectation on its second.
   dir_row_type directed_rows [N_ROWS] = '{
      // Pop right after reset: the queue is empty.
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b1, spq_pkg::ST_EMPTY, 32'sh0,        1'b1, 1'b0, 5'd0},
      // Largest value and priority go in and come straight back out.
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh7FFFFFFF, 16'sh7FFF,
        1'b1, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd1},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b1, spq_pkg::ST_DONE,  32'sh7FFFFFFF, 1'b1, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh80000000, 16'sh8000,
        1'b1, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd1},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'shFFFFFFFF, 16'sh0000,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      // Ties with the lowest priority and with zero: arrival order must hold.
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000005, 16'sh8000,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh55555555, 16'sh5555,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'shAAAAAAAA, 16'shAAAA,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000007, 16'sh0000,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      // Capacity lowered below the six held entries: pushes bounce, pops drain.
      '{ROW_CAP,  spq_pkg::OP_PUSH, 32'sd3,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000009, 16'sh0001,
        1'b1, spq_pkg::ST_FULL,  32'sh0,        1'b0, 1'b1, 5'd6},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'shFFFFFFFF, 16'shFFFF,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      // Capacity zero: the queue reads as full and rejects every push.
      '{ROW_CAP,  spq_pkg::OP_PUSH, 32'sd0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000001, 16'sh0001,
        1'b1, spq_pkg::ST_FULL,  32'sh0,        1'b0, 1'b1, 5'd2},
      // Capacity above the depth: two pushes go in, then pops drain the queue and find it empty.
      '{ROW_CAP,  spq_pkg::OP_PUSH, 32'sd31,       16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000000, 16'sh7FFF,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000003, 16'sh8000,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b1, spq_pkg::ST_EMPTY, 32'sh0,        1'b1, 1'b0, 5'd0},
      // Smallest nonzero capacity: one push fills the queue, the next bounces.
      '{ROW_CAP,  spq_pkg::OP_PUSH, 32'sd1,        16'sh0,
        1'b0, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b0, 5'd0},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh12345678, 16'sh0000,
        1'b1, spq_pkg::ST_DONE,  32'sh0,        1'b0, 1'b1, 5'd1},
      '{ROW_WORD, spq_pkg::OP_PUSH, 32'sh00000002, 16'shFFFB,
        1'b1, spq_pkg::ST_FULL,  32'sh0,        1'b0, 1'b1, 5'd1},
      '{ROW_WORD, spq_pkg::OP_POP,  32'sh0,        16'sh0,
        1'b1, spq_pkg::ST_DONE,  32'sh12345678, 1'b1, 1'b0, 5'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CAP_W-1:0]      csr_wr_data;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the queue: sorted entries with the front at index 0.
   logic signed [VALUE_W-1:0] shadow_value [DEPTH];
   logic signed [PRIO_W-1:0]  shadow_prio  [DEPTH];
   int                        shadow_count;
   logic [CAP_W-1:0]          shadow_cap;

   rsp_word_type pending_results [$];  // expected response words, oldest first
   int           words_taken;          // request words accepted so far
   int           fault_count;

   // The sender hands a typed expectation to the monitor through these two.
   bit           typed_pending;
   rsp_word_type typed_word;

   // Idle controls; phases switch them to get stretches without any gaps.
   bit        sender_gapless;
   bit        sink_steady;
   int        stall_left;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request word to the shadow queue and return the response it
   // must produce. A push lands after every entry with an equal or smaller
   // priority, which keeps equal priorities in arrival order.
   function automatic rsp_word_type predict_queue_op(spq_pkg::op_type op,
                                                     logic signed [VALUE_W-1:0] value,
                                                     logic signed [PRIO_W-1:0] prio);
      rsp_word_type r;
      int           limit;
      int           pos;
      int           i;
      limit    = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
      r.status = spq_pkg::ST_DONE;
      r.popped = '0;
      if (op == spq_pkg::OP_PUSH) begin
         if (shadow_count >= limit) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = value;
            shadow_prio[pos]  = prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.popped = shadow_value[0];
            for (i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      r.empty = (shadow_count == 0);
      r.full  = (shadow_count >= limit);
      r.count = COUNT_OUT_W'(shadow_count);
      return r;
   endfunction

   // Monitor. Everything here is sampled at the rising edge; the testbench
   // only changes inputs at the falling edge, so the values are settled.
   // The response is handled before the request: the response word is registered,
   // so a response can never belong to a word accepted at the same edge.
   always @(posedge clock) begin : monitor
      rsp_word_type exp_w;
      rsp_word_type got_w;
      if (!reset) begin
         if (csr_wr_en) shadow_cap = csr_wr_data;

         if (rsp_chan.valid && rsp_chan.ready) begin
            got_w.status = spq_pkg::status_type'(rsp_chan.status);
            got_w.popped = rsp_chan.popped_value;
            got_w.empty  = rsp_chan.is_empty;
            got_w.full   = rsp_chan.is_full;
            got_w.count  = rsp_chan.entry_count;
            if (pending_results.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: response word with nothing expected: status %0d value %h",
                           $realtime, got_w.status, got_w.popped);
            end else begin
               exp_w = pending_results.pop_front();
               if (got_w.status !== exp_w.status || got_w.popped !== exp_w.popped ||
                   got_w.empty !== exp_w.empty || got_w.full !== exp_w.full ||
                   got_w.count !== exp_w.count) begin
                  fault_count++;
                  // Fields are status/value/empty/full/count in both groups.
                  if (fault_count <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected %0d/%h/%b/%b/%0d got %0d/%h/%b/%b/%0d",
                              $realtime, exp_w.status, exp_w.popped, exp_w.empty,
                              exp_w.full, exp_w.count, got_w.status, got_w.popped,
                              got_w.empty, got_w.full, got_w.count);
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            exp_w = predict_queue_op(spq_pkg::op_type'(req_chan.opcode),
                                     req_chan.item_value, req_chan.item_priority);
            if (typed_pending) exp_w = typed_word;
            pending_results.push_back(exp_w);
            words_taken++;
         end
      end
   end

   // Receiver: holds ready low for stretches of random length, mostly short.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
         rsp_chan.ready <= 1'b0;
         stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 29)
                                                  : $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Idle cycles to leave before the next request word.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_gapless || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Called at a falling edge. Sends one request word and returns at the
   // falling edge after it was taken, with valid still high so that a word
   // sent next without a gap follows back to back.
   task automatic send_word(spq_pkg::op_type op, logic signed [VALUE_W-1:0] value,
                            logic signed [PRIO_W-1:0] prio, bit typed,
                            rsp_word_type typed_rsp);
      int gap;
      int seen;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.item_value    <= value;
      req_chan.item_priority <= prio;
      typed_pending = typed;
      typed_word    = typed_rsp;
      seen          = words_taken;
      do @(negedge clock); while (words_taken == seen);
   endtask

   // Stop sending and wait until every expected response word is back.
   // Every request word yields a response, so the queue is idle by then.
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      wait_results_drained();
      csr_wr_data <= cap;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      rsp_word_type    typed_rsp;
      rsp_word_type    no_rsp;
      int              phase_caps [N_PHASES];
      int              row;
      int              ph;
      int              k;
      int              run_left;
      int              push_pct;
      bit              filling;
      spq_pkg::op_type op;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;

      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_wr_en              = 1'b0;
      csr_wr_data            = '0;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = 1'b0;
      req_chan.item_value    = '0;
      req_chan.item_priority = '0;
      rsp_chan.ready         = 1'b0;
      stall_left             = 0;
      sender_gapless         = 1'b0;
      sink_steady            = 1'b0;
      typed_pending          = 1'b0;
      words_taken            = 0;
      fault_count            = 0;
      shadow_count           = 0;
      shadow_cap             = spq_pkg::CAP_RESET;
      no_rsp                 = '{spq_pkg::ST_DONE, '0, 1'b0, 1'b0, '0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: walk the table.
      for (row = 0; row < N_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_CAP) begin
            write_capacity(CAP_W'(directed_rows[row].value));
         end else begin
            typed_rsp = '{directed_rows[row].st, directed_rows[row].popped,
                          directed_rows[row].empty, directed_rows[row].full,
                          directed_rows[row].count};
            send_word(directed_rows[row].op, directed_rows[row].value,
                      directed_rows[row].prio, directed_rows[row].typed, typed_rsp);
         end
      end

      // Random part: one capacity per phase, the extremes among them. The
      // entries left over from one phase carry into the next, so a lower
      // capacity often starts below the held count.
      phase_caps = '{16, 1, 2, 31, 0, 8, 16, 0};
      phase_caps[N_PHASES-1] = $urandom_range(1, DEPTH);
      filling = 1'b1;
      for (ph = 0; ph < N_PHASES; ph++) begin
         write_capacity(CAP_W'(phase_caps[ph]));
         sender_gapless = (ph % 3 == 1);
         sink_steady    = (ph % 4 == 2);
         run_left       = 0;
         for (k = 0; k < PHASE_WORDS; k++) begin
            // Alternate runs that lean toward pushes with runs that lean
            // toward pops, so the queue swings between full and empty.
            if (run_left == 0) begin
               push_pct = filling ? 75 : 30;
               filling  = !filling;
               run_left = $urandom_range(10, 40);
            end
            run_left--;

            // Once, the sender holds off until every response is back.
            if (ph == 2 && k == PHASE_WORDS / 2) wait_results_drained();

            op = ($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
            value = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? 32'sh7FFFFFFF
                                                                       : 32'sh80000000)
                                                 : $urandom;
            // Half the time a narrow band of priorities, so that ties are common.
            case ($urandom_range(0, 9)) inside
               [0:4]:   prio = PRIO_W'($signed($urandom_range(0, 8)) - 4);
               5:       prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               default: prio = PRIO_W'($urandom);
            endcase
            send_word(op, value, prio, 1'b0, no_rsp);
         end
      end

      sender_gapless = 1'b0;
      wait_results_drained();
      repeat (5) @(negedge clock);

      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("tb_sorted_priority_queue: PASS");
      end else begin
         $display("tb_sorted_priority_queue: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of about 700 words.
   initial begin
      #5_000_000;
      $display("tb_sorted_priority_queue: FAIL");
      $finish;
   end

endmodule
